// ===== src/rsmc_pkg.sv =====
`timescale 1ns / 1ps

package rsmc_pkg;

  // fixed port field widths
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned INDEX_W = 11;

  // input word kinds (s_tuser[0])
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // fill_mode codes; the spare code behaves as the mirror
  localparam logic [1:0] FILL_MIRROR = 2'd0;
  localparam logic [1:0] FILL_REPEAT = 2'd1;
  localparam logic [1:0] FILL_MIN    = 2'd2;

  // result of index mapping for one read
  typedef struct packed {
    logic err;      // short scan or index past end
    logic use_min;  // back-half entry taken from the scan minimum
  } map_t;

endpackage

// ===== src/rsmc_store.sv =====
`timescale 1ns / 1ps

// Sample store: one write port, one read port, registered read data
module rsmc_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rsmc_map.sv =====
`timescale 1ns / 1ps

// Maps a rotated completed-scan position to a store address
module rsmc_map #(
  parameter int unsigned CW       = 11,
  parameter int unsigned AW       = 10
) (
  input  logic [CW-1:0]                  count,
  input  logic [rsmc_pkg::INDEX_W-1:0]   out_index,
  input  logic [1:0]                     fill_mode,
  output logic [AW-1:0]                  addr,
  output rsmc_pkg::map_t                 flags,
  output logic [rsmc_pkg::INDEX_W-1:0]   completed_length
);

  // working width: holds 2*count and the 11-bit index
  localparam int unsigned LW = CW + 1;
  localparam int unsigned EW = (LW > rsmc_pkg::INDEX_W) ? LW : rsmc_pkg::INDEX_W;
  localparam int unsigned MW = EW + 1;

  logic          long_enough;
  logic [MW-1:0] n_w;
  logic [MW-1:0] len_w;
  logic [MW-1:0] idx_w;
  logic [MW-1:0] src_raw;
  logic [MW-1:0] src;
  logic [MW-1:0] j;

  assign long_enough = (count >= CW'(2));
  assign n_w         = MW'(count);
  assign len_w       = long_enough ? ((n_w << 1) - MW'(2)) : '0;
  assign idx_w       = MW'(out_index);
  assign completed_length = len_w[rsmc_pkg::INDEX_W-1:0];

  // rotate right by len/4: src = (idx + len - len/4) mod len
  assign src_raw = idx_w + len_w - (len_w >> 2);
  assign src     = (src_raw >= len_w) ? (src_raw - len_w) : src_raw;
  assign j       = src - n_w;

  always_comb begin
    flags.err     = !long_enough || (idx_w >= len_w);
    flags.use_min = 1'b0;
    addr          = AW'(src);
    if (src >= n_w) begin
      priority if (fill_mode == rsmc_pkg::FILL_MIN) begin
        flags.use_min = 1'b1;
      end else if (fill_mode == rsmc_pkg::FILL_REPEAT) begin
        addr = AW'(j + MW'(1));
      end else begin
        addr = AW'(n_w - MW'(2) - j);
      end
    end
  end

endmodule

// ===== src/range_scan_mirror_completion_unit.sv =====
`timescale 1ns / 1ps

// Load words give no result; a read word's result is registered by the store
// read, then by the output register. Throughput, set by the single-port-per-side
// store, is one word per cycle while m_tready does not stall the result stream.
// rst (synchronous) clears sample count, min range, fill_mode and the
// pipeline valids; the sample store is not cleared and needs no sweep.
module range_scan_mirror_completion_unit #(
  parameter int unsigned MAX_RAYS    = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: fill_mode
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_wdata,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] sample_value, [26:16] out_index, rest zero
  input  logic [1:0]  s_tuser,   // [0] kind, [1] first
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] value, [26:16] completed_length, rest zero
  output logic        m_tuser    // [0] error
);

  localparam int unsigned AW = (MAX_RAYS > 1) ? $clog2(MAX_RAYS) : 1;
  localparam int unsigned CW = $clog2(MAX_RAYS + 1);
  localparam int unsigned SB = SAMPLE_BITS;

  // scan state
  logic [CW-1:0] count;
  logic [SB-1:0] scan_min;
  logic [1:0]    fill_mode;

  // read stage and output register
  logic                          s1_valid;
  rsmc_pkg::map_t                s1_flags;
  logic [SB-1:0]                 s1_min;
  logic [rsmc_pkg::INDEX_W-1:0]  s1_len;
  logic [rsmc_pkg::VALUE_W-1:0]  out_value;
  logic                          out_err;
  logic [rsmc_pkg::INDEX_W-1:0]  out_len;

  logic                          accept;
  logic                          is_load;
  logic                          is_read;
  logic                          s1_advance;
  logic [SB-1:0]                 sample;
  logic [CW-1:0]                 count_base;
  logic [SB-1:0]                 min_base;
  logic                          store_we;
  logic [AW-1:0]                 rd_addr;
  logic [SB-1:0]                 rd_data;
  rsmc_pkg::map_t                map_flags;
  logic [rsmc_pkg::INDEX_W-1:0]  map_len;
  logic [SB-1:0]                 s1_data;

  // handshake
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign accept     = s_tvalid && s_tready;
  assign is_load    = accept && (s_tuser[0] == rsmc_pkg::KIND_LOAD);
  assign is_read    = accept && (s_tuser[0] == rsmc_pkg::KIND_READ);

  // load path: first clears the scan, a full store drops the sample
  assign sample     = SB'(s_tdata[rsmc_pkg::VALUE_W-1:0]);
  assign count_base = s_tuser[1] ? '0 : count;
  assign min_base   = s_tuser[1] ? '1 : scan_min;
  assign store_we   = is_load && (count_base < CW'(MAX_RAYS));

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scan_min <= '1;
    end else if (is_load) begin
      if (store_we) begin
        count    <= count_base + CW'(1);
        scan_min <= (sample < min_base) ? sample : min_base;
      end else begin
        count    <= count_base;
        scan_min <= min_base;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode <= rsmc_pkg::FILL_MIRROR;
    end else if (cfg_wen) begin
      fill_mode <= cfg_wdata;
    end
  end

  rsmc_map #(
    .CW       (CW),
    .AW       (AW)
  ) u_map (
    .count            (count),
    .out_index        (s_tdata[16 +: rsmc_pkg::INDEX_W]),
    .fill_mode        (fill_mode),
    .addr             (rd_addr),
    .flags            (map_flags),
    .completed_length (map_len)
  );

  rsmc_store #(
    .DEPTH (MAX_RAYS),
    .AW    (AW),
    .DW    (SB)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_base[AW-1:0]),
    .wdata (sample),
    .re    (is_read),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // read stage: waits on store data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      s1_flags <= map_flags;
      s1_min   <= scan_min;
      s1_len   <= map_len;
    end
  end

  // value select
  assign s1_data = s1_flags.err ? '0 : (s1_flags.use_min ? s1_min : rd_data);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_value <= rsmc_pkg::VALUE_W'(s1_data);
      out_err   <= s1_flags.err;
      out_len   <= s1_len;
    end
  end

  assign m_tdata = {5'b0, out_len, out_value};
  assign m_tuser = out_err;

endmodule

// ===== src/rsmc_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the result stream
module rsmc_checker #(
  parameter int unsigned MAX_RAYS = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // an error word carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] == 16'd0)
    else $error("error word with nonzero value");

  // completed length is 2N-2 (zero for a short scan), always even
  a_len_even: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[16])
    else $error("odd completed length");

  // an empty completed scan can only answer with an error
  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    (MAX_RAYS <= 1024) && m_tvalid && (m_tdata[26:16] == 11'd0) |-> m_tuser)
    else $error("valid value from empty scan");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word after reset");

endmodule

bind range_scan_mirror_completion_unit rsmc_checker #(
  .MAX_RAYS (MAX_RAYS)
) u_rsmc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
